[rtl/plc_pkg.sv]
package plc_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 7;
  localparam int OP_W     = 2;
  localparam int CNT_W    = 7;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // compare width: wide enough for any position or length plus one
  localparam int CW       = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int GRP_SZ   = 8;
  localparam int GRP_IW   = $clog2(GRP_SZ);
  localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;
  localparam int NPAD     = NGRP * GRP_SZ;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] out_value;
    logic [CNT_W-1:0]  found_at;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              go;
    logic              ins_ok;
    logic              del_ok;
    logic              rd_en;
    logic              loc_en;
    logic [CW-1:0]     pos;
    logic [CW-1:0]     len;
    logic [DATA_W-1:0] val;
  } cell_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [GRP_IW-1:0] first;
    logic [DATA_W-1:0] data;
  } grp_res_t;

endpackage

[rtl/plc_cell.sv]
module plc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plc_pkg::cell_ctrl_t          ctrl_i,
  input  logic [plc_pkg::IDX_W-1:0]    idx_i,
  input  logic [plc_pkg::DATA_W-1:0]   left_i,
  input  logic [plc_pkg::DATA_W-1:0]   right_i,
  output logic [plc_pkg::DATA_W-1:0]   data_o,
  output logic                         hit_o,
  output logic [plc_pkg::DATA_W-1:0]   sel_o
);

  logic [plc_pkg::DATA_W-1:0] data_q, data_d;
  logic [plc_pkg::DATA_W-1:0] sel_q, sel_d;
  logic                       hit_q, hit_d;
  logic [plc_pkg::CW-1:0]     kk;
  logic [plc_pkg::CW-1:0]     kk1;
  logic                       ins_put, ins_shift, del_shift;

  assign kk  = plc_pkg::CW'(idx_i);
  assign kk1 = kk + plc_pkg::CW'(1);

  always_comb begin
    ins_put   = ctrl_i.ins_ok && (kk1 == ctrl_i.pos);
    ins_shift = ctrl_i.ins_ok && (kk >= ctrl_i.pos) && (kk <= ctrl_i.len);
    del_shift = ctrl_i.del_ok && (kk1 >= ctrl_i.pos) && (kk1 < ctrl_i.len);
    data_d = data_q;
    if (ins_put) begin
      data_d = ctrl_i.val;
    end else if (ins_shift) begin
      data_d = left_i;
    end else if (del_shift) begin
      data_d = right_i;
    end
    // read and compare see the contents before this request's shift
    sel_d = (ctrl_i.rd_en && (kk1 == ctrl_i.pos)) ? data_q : '0;
    hit_d = ctrl_i.loc_en && (kk < ctrl_i.len) && (data_q == ctrl_i.val);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      data_q <= data_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.go) begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;
  assign sel_o  = sel_q;

endmodule

[rtl/plc_group.sv]
module plc_group (
  input  logic                                          clk_i,
  input  logic [plc_pkg::GRP_SZ-1:0]                    hit_i,
  input  logic [plc_pkg::GRP_SZ-1:0][plc_pkg::DATA_W-1:0] sel_i,
  output plc_pkg::grp_res_t                             res_o
);

  plc_pkg::grp_res_t res_q, res_d;

  always_comb begin
    res_d.hit   = |hit_i;
    res_d.first = '0;
    res_d.data  = '0;
    // scan down so the lowest hit wins
    for (int i = plc_pkg::GRP_SZ - 1; i >= 0; i--) begin
      if (hit_i[i]) begin
        res_d.first = plc_pkg::GRP_IW'(i);
      end
    end
    for (int i = 0; i < plc_pkg::GRP_SZ; i++) begin
      res_d.data = res_d.data | sel_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[rtl/positional_list_store_core.sv]
// Positional list store: an ordered list of byte elements, positions from 1.
// Request channel: in_valid_i / in_stall_o carry in_req_i (operation,
// position, value). Response channel: out_valid_o / out_stall_i carry
// out_rsp_o (ok, out_value, found_at, count, is_empty). A transfer happens
// on a clock edge with valid high and stall low; one response per request.
// The elements sit in a row of cells; insert and delete shift them in place
// in the accept cycle. Get, delete readout and locate are resolved over
// the cells by a registered two-level tree (groups of eight cells, then
// across groups).
// The response passes the cell registers, the group registers and the
// response register before it is valid. A new request is taken only while
// idle or in the cycle the response leaves, so a request is never taken
// before the last one is through.
// While the response is stalled it holds, and no new request is taken.
// Reset (rst_ni low, asynchronous) empties the list; cell contents are
// not cleared and are never read outside the current length.
module positional_list_store_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  plc_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output plc_pkg::rsp_t   out_rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CELL  = 4'b0010,
    ST_GROUP = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                       in_acc, out_acc;
  logic [plc_pkg::LEN_W-1:0]  len_q, len_d;
  logic                       ok_q, ok_d;
  plc_pkg::op_e               op_q, op_in;
  plc_pkg::rsp_t              rsp_q, rsp_d;
  plc_pkg::cell_ctrl_t        ctrl;
  logic [plc_pkg::CW-1:0]     pos_w, len_w;
  logic                       ins_ok, rd_ok;

  logic [plc_pkg::CAPACITY-1:0][plc_pkg::DATA_W-1:0] cell_data;
  logic [plc_pkg::NPAD-1:0]                          hit_all;
  logic [plc_pkg::NPAD-1:0][plc_pkg::DATA_W-1:0]     sel_all;
  plc_pkg::grp_res_t [plc_pkg::NGRP-1:0]             grp;

  logic                       any_hit;
  logic [plc_pkg::LEN_W-1:0]  found;
  logic [plc_pkg::DATA_W-1:0] rd_data;

  assign out_acc    = (state_q == ST_OUT) && !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || out_acc);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign op_in = plc_pkg::op_e'(in_req_i.operation);
  assign pos_w = plc_pkg::CW'(in_req_i.position);
  assign len_w = plc_pkg::CW'(len_q);

  always_comb begin
    ins_ok = (pos_w != '0) && (pos_w <= len_w + plc_pkg::CW'(1))
             && (len_w < plc_pkg::CW'(plc_pkg::CAPACITY));
    rd_ok  = (pos_w != '0) && (pos_w <= len_w);
    ctrl.go     = in_acc;
    ctrl.ins_ok = in_acc && (op_in == plc_pkg::OP_INSERT) && ins_ok;
    ctrl.del_ok = in_acc && (op_in == plc_pkg::OP_DELETE) && rd_ok;
    ctrl.rd_en  = ((op_in == plc_pkg::OP_DELETE) || (op_in == plc_pkg::OP_GET)) && rd_ok;
    ctrl.loc_en = (op_in == plc_pkg::OP_LOCATE);
    ctrl.pos    = pos_w;
    ctrl.len    = len_w;
    ctrl.val    = in_req_i.value;
    len_d = len_q;
    if (ctrl.ins_ok) begin
      len_d = len_q + plc_pkg::LEN_W'(1);
    end else if (ctrl.del_ok) begin
      len_d = len_q - plc_pkg::LEN_W'(1);
    end
    ok_d = ctrl.ins_ok || ctrl.del_ok || ctrl.rd_en;
  end

  for (genvar k = 0; k < plc_pkg::NPAD; k++) begin : g_cell
    if (k < plc_pkg::CAPACITY) begin : g_real
      logic [plc_pkg::DATA_W-1:0] left, right;
      if (k == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_data[k-1];
      end
      if (k == plc_pkg::CAPACITY - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_data[k+1];
      end
      plc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .idx_i   (plc_pkg::IDX_W'(k)),
        .left_i  (left),
        .right_i (right),
        .data_o  (cell_data[k]),
        .hit_o   (hit_all[k]),
        .sel_o   (sel_all[k])
      );
    end else begin : g_pad
      assign hit_all[k] = 1'b0;
      assign sel_all[k] = '0;
    end
  end

  for (genvar g = 0; g < plc_pkg::NGRP; g++) begin : g_grp
    plc_group u_group (
      .clk_i (clk_i),
      .hit_i (hit_all[g*plc_pkg::GRP_SZ +: plc_pkg::GRP_SZ]),
      .sel_i (sel_all[g*plc_pkg::GRP_SZ +: plc_pkg::GRP_SZ]),
      .res_o (grp[g])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    found   = '0;
    rd_data = '0;
    for (int g = plc_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp[g].hit) begin
        any_hit = 1'b1;
        found   = plc_pkg::LEN_W'(g * plc_pkg::GRP_SZ) + plc_pkg::LEN_W'(grp[g].first)
                  + plc_pkg::LEN_W'(1);
      end
    end
    for (int g = 0; g < plc_pkg::NGRP; g++) begin
      rd_data = rd_data | grp[g].data;
    end
    rsp_d.ok        = (op_q == plc_pkg::OP_LOCATE) ? any_hit : ok_q;
    rsp_d.out_value = rd_data;
    rsp_d.found_at  = (op_q == plc_pkg::OP_LOCATE) ? plc_pkg::CNT_W'(found) : '0;
    rsp_d.count     = plc_pkg::CNT_W'(len_q);
    rsp_d.is_empty  = (len_q == '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CELL;
      end
      ST_CELL:  state_d = ST_GROUP;
      ST_GROUP: state_d = ST_OUT;
      ST_OUT: begin
        if (in_acc) begin
          state_d = ST_CELL;
        end else if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_in;
      ok_q <= ok_d;
    end
    if (state_q == ST_GROUP) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= plc_pkg::LEN_W'(plc_pkg::CAPACITY))
    else $error("list length beyond capacity");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_ok |=> (len_q == $past(len_q) + plc_pkg::LEN_W'(1)))
    else $error("insert did not grow the list");

  a_loc_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.found_at != '0) |-> out_rsp_o.ok)
    else $error("match position without ok");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

[tb/tb_positional_list_store_core.sv]
`timescale 1ns / 1ps

module tb_positional_list_store_core;

  localparam int          CLK_HALF    = 4;
  localparam int          PHASE_ITEMS = 433;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  plc_pkg::req_t  in_req_i;
  logic           out_valid_o;
  logic           out_stall_i;
  plc_pkg::rsp_t  out_rsp_o;

  positional_list_store_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // list as the block should hold it
  logic [plc_pkg::DATA_W-1:0] shadow_list [plc_pkg::CAPACITY];
  int                         shadow_len = 0;
  // length as the stimulus plan expects it to be once its requests are taken
  int                         plan_len = 0;

  plc_pkg::req_t req_backlog [$];
  plc_pkg::rsp_t due_rsps [$];
  plc_pkg::rsp_t head_rsp;
  logic          req_taken = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   rsp_stall_pct = 0;
  int unsigned   reqs_issued = 0;
  int unsigned   reqs_taken = 0;
  int unsigned   rsps_seen = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   err_cnt = 0;
  int unsigned   full_refusals = 0;
  int unsigned   op_total [4] = '{default: 0};
  int unsigned   op_ok [4] = '{default: 0};

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic plc_pkg::rsp_t apply_list_op(plc_pkg::req_t r);
    plc_pkg::rsp_t res;
    int            p;
    int            k;
    res = '0;
    p = int'(r.position);
    case (r.operation)
      plc_pkg::OP_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < plc_pkg::CAPACITY) begin
          for (k = shadow_len; k > p - 1; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = r.value;
          shadow_len++;
          res.ok = 1'b1;
        end else if (shadow_len == plc_pkg::CAPACITY) begin
          full_refusals++;
        end
      end
      plc_pkg::OP_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          res.out_value = shadow_list[p-1];
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      plc_pkg::OP_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          res.out_value = shadow_list[p-1];
          res.ok = 1'b1;
        end
      end
      default: begin
        // first match within the current length only
        for (k = 0; k < shadow_len; k++) begin
          if (!res.ok && shadow_list[k] == r.value) begin
            res.found_at = plc_pkg::CNT_W'(k + 1);
            res.ok = 1'b1;
          end
        end
      end
    endcase
    res.count = plc_pkg::CNT_W'(shadow_len);
    res.is_empty = (shadow_len == 0);
    op_total[r.operation]++;
    if (res.ok) op_ok[r.operation]++;
    return res;
  endfunction

  function automatic void add_req(plc_pkg::op_e op, int unsigned pos,
                                  logic [plc_pkg::DATA_W-1:0] val);
    plc_pkg::req_t r;
    r.operation = op;
    r.position = plc_pkg::POS_W'(pos);
    r.value = val;
    req_backlog.push_back(r);
    reqs_issued++;
    case (op)
      plc_pkg::OP_INSERT:
        if (pos >= 1 && pos <= plan_len + 1 && plan_len < plc_pkg::CAPACITY) plan_len++;
      plc_pkg::OP_DELETE: if (pos >= 1 && pos <= plan_len) plan_len--;
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_pos(int unsigned hi);
    // favor both ends of the valid range
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return hi;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  function automatic logic [plc_pkg::DATA_W-1:0] pick_val();
    logic [plc_pkg::DATA_W-1:0] v;
    if ($urandom_range(0, 2) == 0) return plc_pkg::DATA_W'($urandom_range(0, 255));
    // small alphabet near both extremes so locate hits often
    v = plc_pkg::DATA_W'($urandom_range(0, 5));
    if ($urandom_range(0, 1) == 1) v = ~v;
    return v;
  endfunction

  function automatic void gen_burst();
    int unsigned  n;
    int unsigned  i;
    int unsigned  sel;
    plc_pkg::op_e op;
    case ($urandom_range(0, 9))
      0, 1: begin
        // fill to capacity, then push past it
        while (plan_len < plc_pkg::CAPACITY) begin
          if ($urandom_range(0, 4) == 0)
            add_req(plc_pkg::OP_LOCATE, $urandom_range(0, 127), pick_val());
          else add_req(plc_pkg::OP_INSERT, pick_pos(plan_len + 1), pick_val());
        end
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          add_req(plc_pkg::OP_INSERT, $urandom_range(1, plc_pkg::CAPACITY + 1), pick_val());
      end
      2, 3: begin
        // drain to empty, then poke the empty list
        while (plan_len > 0) begin
          if ($urandom_range(0, 4) == 0)
            add_req(plc_pkg::OP_GET, pick_pos(plan_len), pick_val());
          else add_req(plc_pkg::OP_DELETE, pick_pos(plan_len), pick_val());
        end
        add_req(plc_pkg::op_e'($urandom_range(1, 3)), $urandom_range(0, 127), pick_val());
      end
      4, 5, 6, 7: begin
        n = $urandom_range(10, 30);
        for (i = 0; i < n; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 35) add_req(plc_pkg::OP_INSERT, pick_pos(plan_len + 1), pick_val());
          else if (sel < 80) begin
            op = (sel < 60) ? plc_pkg::OP_DELETE : plc_pkg::OP_GET;
            if (plan_len > 0) add_req(op, pick_pos(plan_len), pick_val());
            else add_req(op, $urandom_range(0, 127), pick_val());
          end else add_req(plc_pkg::OP_LOCATE, $urandom_range(0, 127), pick_val());
        end
      end
      8: begin
        n = $urandom_range(5, 15);
        for (i = 0; i < n; i++)
          add_req(plc_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 127),
                  plc_pkg::DATA_W'($urandom_range(0, 255)));
      end
      default: begin
        // out-of-range positions: zero or past the end
        n = $urandom_range(3, 8);
        for (i = 0; i < n; i++) begin
          op = plc_pkg::op_e'($urandom_range(0, 2));
          if ($urandom_range(0, 2) == 0) add_req(op, 0, pick_val());
          else if (op == plc_pkg::OP_INSERT)
            add_req(op, $urandom_range(plan_len + 2, 127), pick_val());
          else add_req(op, $urandom_range(plan_len + 1, 127), pick_val());
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch on response %0d: %s", $time, rsps_seen, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // driver: present the next request once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req_i <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  // monitor: predict on each taken request, check each delivered response
  always @(posedge clk_i) begin
    cycle_cnt++;
    req_taken = rst_ni && in_valid_i && !in_stall_o;
    if (req_taken) begin
      due_rsps.push_back(apply_list_op(in_req_i));
      reqs_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_rsps.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        head_rsp = due_rsps.pop_front();
        check_field("ok", 32'(out_rsp_o.ok), 32'(head_rsp.ok));
        check_field("out_value", 32'(out_rsp_o.out_value), 32'(head_rsp.out_value));
        check_field("found_at", 32'(out_rsp_o.found_at), 32'(head_rsp.found_at));
        check_field("count", 32'(out_rsp_o.count), 32'(head_rsp.count));
        check_field("is_empty", 32'(out_rsp_o.is_empty), 32'(head_rsp.is_empty));
      end
      rsps_seen++;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("positional_list_store_core verification failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned target;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, bad positions, both ends, duplicates
    add_req(plc_pkg::OP_LOCATE, 0, 8'h00);
    add_req(plc_pkg::OP_GET, 1, 8'h00);
    add_req(plc_pkg::OP_DELETE, 1, 8'h00);
    add_req(plc_pkg::OP_INSERT, 0, 8'h11);
    add_req(plc_pkg::OP_INSERT, 2, 8'h22);
    add_req(plc_pkg::OP_INSERT, 127, 8'h00);
    add_req(plc_pkg::OP_INSERT, 1, 8'hFF);
    add_req(plc_pkg::OP_INSERT, 1, 8'h00);
    add_req(plc_pkg::OP_INSERT, 3, 8'hA5);
    add_req(plc_pkg::OP_INSERT, 2, 8'h5A);
    add_req(plc_pkg::OP_INSERT, 6, 8'h77);
    add_req(plc_pkg::OP_GET, 1, 8'h00);
    add_req(plc_pkg::OP_GET, 4, 8'hFF);
    add_req(plc_pkg::OP_GET, 5, 8'h00);
    add_req(plc_pkg::OP_GET, 0, 8'h00);
    add_req(plc_pkg::OP_GET, 127, 8'hFF);
    add_req(plc_pkg::OP_LOCATE, 127, 8'hA5);
    add_req(plc_pkg::OP_INSERT, 2, 8'hA5);
    add_req(plc_pkg::OP_LOCATE, 0, 8'hA5);
    add_req(plc_pkg::OP_LOCATE, 64, 8'h33);
    add_req(plc_pkg::OP_DELETE, 6, 8'h00);
    add_req(plc_pkg::OP_DELETE, 5, 8'h00);
    add_req(plc_pkg::OP_DELETE, 1, 8'hFF);
    add_req(plc_pkg::OP_DELETE, 0, 8'h00);
    add_req(plc_pkg::OP_DELETE, 127, 8'h00);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 8;  rsp_stall_pct = 62; end
        1:       begin send_idle_pct = 62; rsp_stall_pct = 8;  end
        default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
      target = reqs_issued + PHASE_ITEMS;
      while (reqs_issued < target) gen_burst();
      while (reqs_taken != reqs_issued || due_rsps.size() != 0) @(posedge clk_i);
    end
    // catch any stray response
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests: insert %0d/%0d ok, delete %0d/%0d, get %0d/%0d,",
             reqs_taken, op_ok[plc_pkg::OP_INSERT], op_total[plc_pkg::OP_INSERT],
             op_ok[plc_pkg::OP_DELETE], op_total[plc_pkg::OP_DELETE],
             op_ok[plc_pkg::OP_GET], op_total[plc_pkg::OP_GET]);
    $display("locate %0d/%0d, %0d inserts refused on a full list, %0d responses checked",
             op_ok[plc_pkg::OP_LOCATE], op_total[plc_pkg::OP_LOCATE], full_refusals,
             rsps_seen);
    if (err_cnt == 0) begin
      $display("positional_list_store_core verification clean");
    end else begin
      $display("positional_list_store_core verification failed");
    end
    $finish;
  end

endmodule
